// ----- rtl/ptb_pkg.sv -----
// Shared constants for the palindromic tree builder.
package ptb_pkg;
	localparam int MAX_LEN_DEF  = 4096;
	localparam int ALPHABET_DEF = 26;
	localparam int SYM_W        = 5;
	localparam int OUT_W        = 13;
endpackage

// ----- rtl/palindromic_tree_builder.sv -----
// Palindromic tree (eertree) builder: one letter per transaction, multi-cycle sequencer.
//
//  channel   signals                                    direction  handshake
//  command   start, busy, symbol                        in         start & !busy
//  result    done, suffix_length, suffix_node, created, out        done strobe, one cycle
//            occurrences, distinct_count, full_res
//
// An ignored letter (store full or symbol out of range) is answered from IDLE without a walk.
// A letter walks suffix links, each hop through W_LEN (len/link read), W_POS (text read)
// and W_CMP (compare); C_RD, C_PL and C_VAL look up the child; F_RD and HIT_UPD or CREATE end it.
// No clearing pass: a child entry counts only if the node it names exists and records
// the same parent and letter. Reset gives two roots and an empty text.
// Results cannot be stalled; done pulses for one cycle per transaction.
module palindromic_tree_builder #(
	parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
	parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ptb_pkg::SYM_W-1:0]   symbol,
	output logic                        done,
	output logic [ptb_pkg::OUT_W-1:0]   suffix_length,
	output logic [ptb_pkg::OUT_W-1:0]   suffix_node,
	output logic                        created,
	output logic [ptb_pkg::OUT_W-1:0]   occurrences,
	output logic [ptb_pkg::OUT_W-1:0]   distinct_count,
	output logic                        full_res
);
	localparam int NODE_CAP = MAX_LEN + 2;
	localparam int TW = $clog2(MAX_LEN + 1);
	localparam int NW = $clog2(NODE_CAP);
	localparam int CW = $clog2(NODE_CAP * ALPHABET);
	localparam int OW = ptb_pkg::OUT_W;
	localparam int SW = ptb_pkg::SYM_W;

	typedef enum logic [3:0] {
		IDLE, W_LEN, W_POS, W_CMP, C_RD, C_PL, C_VAL, F_RD, HIT_UPD, CREATE
	} state_t;

	state_t state_q;

	logic [SW-1:0] text_mem [MAX_LEN+1];
	logic [TW-1:0] len_mem  [NODE_CAP];
	logic [NW-1:0] link_mem [NODE_CAP];
	logic [TW-1:0] cnt_mem  [NODE_CAP];
	logic [NW-1:0] par_mem  [NODE_CAP];
	logic [SW-1:0] let_mem  [NODE_CAP];
	logic [NW-1:0] child_mem [NODE_CAP*ALPHABET];

	logic [SW-1:0] text_rd_q, let_rd_q;
	logic [TW-1:0] len_rd_q, cnt_rd_q;
	logic [NW-1:0] link_rd_q, par_rd_q, child_rd_q;

	logic [TW-1:0] tl_q;
	logic [NW-1:0] last_q, high_q, v_q, cur_q, curlink_q, n_q, link_q;
	logic [SW-1:0] sym_q;
	logic signed [TW:0] lenv_q, curlen_q;
	logic          posok_q, phase_q;

	logic          done_q, created_q, full_q;
	logic [OW-1:0] len_out_q, node_out_q, occ_out_q, dist_out_q;

	// Combinational read addresses and write controls
	logic [NW-1:0] node_ra;
	logic [TW-1:0] text_ra;
	logic [CW-1:0] child_ra, child_wa;
	logic          accept;
	logic signed [TW:0]   lenv;
	logic [NW-1:0]        linkv;
	logic signed [TW+1:0] pos;
	logic                 hit;
	logic [NW-1:0]        fresh;
	logic [TW-1:0]        cnt_next;

	assign accept   = start && (state_q == IDLE);
	assign fresh    = high_q + NW'(1);
	assign cnt_next = cnt_rd_q + TW'(1);
	assign child_ra = CW'(v_q) * CW'(ALPHABET) + CW'(sym_q);
	assign child_wa = CW'(cur_q) * CW'(ALPHABET) + CW'(sym_q);

	always_comb begin
		case (state_q)
			C_PL:    node_ra = child_rd_q;
			// hold the candidate child on the read port until CREATE
			C_VAL:   node_ra = n_q;
			F_RD:    node_ra = n_q;
			default: node_ra = v_q;
		endcase
	end

	always_comb begin
		if (v_q == NW'(0)) begin
			lenv  = '0;
			linkv = NW'(1);
		end else if (v_q == NW'(1)) begin
			lenv  = '1;
			linkv = NW'(0);
		end else begin
			lenv  = $signed({1'b0, len_rd_q});
			linkv = link_rd_q;
		end
		pos     = $signed({2'b00, tl_q}) - (TW+2)'(lenv) - (TW+2)'(1);
		text_ra = pos[TW-1:0];
	end

	assign hit = (n_q >= NW'(2)) && (n_q <= high_q) && (par_rd_q == v_q) &&
		(let_rd_q == sym_q);

	// Memories
	always_ff @(posedge clk) begin
		if (accept && tl_q != TW'(MAX_LEN) && symbol < SW'(ALPHABET))
			text_mem[tl_q + TW'(1)] <= symbol;
		text_rd_q <= text_mem[text_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == CREATE) begin
			len_mem[fresh]  <= TW'(curlen_q + (TW+1)'(2));
			if (hit)
				link_mem[fresh] <= n_q;
			else
				link_mem[fresh] <= NW'(0);
			par_mem[fresh]  <= cur_q;
			let_mem[fresh]  <= sym_q;
		end
		len_rd_q  <= len_mem[node_ra];
		link_rd_q <= link_mem[node_ra];
		par_rd_q  <= par_mem[node_ra];
		let_rd_q  <= let_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == CREATE)
			cnt_mem[fresh] <= TW'(1);
		else if (state_q == HIT_UPD)
			cnt_mem[n_q] <= cnt_next;
		cnt_rd_q <= cnt_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == CREATE)
			child_mem[child_wa] <= fresh;
		child_rd_q <= child_mem[child_ra];
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			tl_q      <= '0;
			last_q    <= '0;
			high_q    <= NW'(1);
			phase_q   <= 1'b0;
			done_q    <= 1'b0;
			created_q <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						if (tl_q == TW'(MAX_LEN) || symbol >= SW'(ALPHABET)) begin
							done_q     <= 1'b1;
							full_q     <= (tl_q == TW'(MAX_LEN));
							created_q  <= 1'b0;
							len_out_q  <= '0;
							node_out_q <= '0;
							occ_out_q  <= '0;
							dist_out_q <= OW'(high_q - NW'(1));
						end else begin
							tl_q    <= tl_q + TW'(1);
							sym_q   <= symbol;
							v_q     <= last_q;
							phase_q <= 1'b0;
							state_q <= W_LEN;
						end
					end
				end
				W_LEN: state_q <= W_POS;
				W_POS: begin
					lenv_q  <= lenv;
					link_q  <= linkv;
					posok_q <= (pos >= (TW+2)'(1));
					state_q <= W_CMP;
				end
				W_CMP: begin
					if (posok_q && text_rd_q == sym_q) begin
						if (!phase_q) begin
							cur_q     <= v_q;
							curlen_q  <= lenv_q;
							curlink_q <= link_q;
						end
						state_q <= C_RD;
					end else begin
						// follow the suffix link
						v_q     <= link_q;
						state_q <= W_LEN;
					end
				end
				C_RD: state_q <= C_PL;
				C_PL: begin
					n_q     <= child_rd_q;
					state_q <= C_VAL;
				end
				C_VAL: begin
					if (phase_q)
						state_q <= CREATE;
					else if (hit)
						state_q <= F_RD;
					else begin
						// search the link target for the new node's suffix link
						phase_q <= 1'b1;
						v_q     <= curlink_q;
						state_q <= W_LEN;
					end
				end
				F_RD: state_q <= HIT_UPD;
				HIT_UPD: begin
					last_q     <= n_q;
					done_q     <= 1'b1;
					full_q     <= 1'b0;
					created_q  <= 1'b0;
					len_out_q  <= OW'(len_rd_q);
					node_out_q <= OW'(n_q);
					occ_out_q  <= OW'(cnt_next);
					dist_out_q <= OW'(high_q - NW'(1));
					state_q    <= IDLE;
				end
				CREATE: begin
					high_q     <= fresh;
					last_q     <= fresh;
					done_q     <= 1'b1;
					full_q     <= 1'b0;
					created_q  <= 1'b1;
					len_out_q  <= OW'(curlen_q + (TW+1)'(2));
					node_out_q <= OW'(fresh);
					occ_out_q  <= OW'(1);
					dist_out_q <= OW'(high_q);
					state_q    <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy           = (state_q != IDLE);
	assign done           = done_q;
	assign suffix_length  = len_out_q;
	assign suffix_node    = node_out_q;
	assign created        = created_q;
	assign occurrences    = occ_out_q;
	assign distinct_count = dist_out_q;
	assign full_res       = full_q;

	a_last_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		last_q <= high_q) else $error("last node beyond highest node");
	a_high_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CREATE) |=> (high_q == $past(high_q) + NW'(1)))
		else $error("node count not advanced on create");
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == CREATE || $past(state_q) == HIT_UPD ||
		$past(start)))
		else $error("result without a transaction");
	a_created_node: assert property (@(posedge clk) disable iff (!arst_n)
		(done && created) |-> (suffix_node == distinct_count + OW'(1)))
		else $error("created node id mismatch");
endmodule

// ----- tb/palindromic_tree_builder_tb.sv -----
// Self-checking testbench for the palindromic tree builder.
`timescale 1ns / 1ps

module palindromic_tree_builder_tb;
	localparam int MAX_LEN   = ptb_pkg::MAX_LEN_DEF;
	localparam int ALPHABET  = ptb_pkg::ALPHABET_DEF;
	localparam int SYM_W     = ptb_pkg::SYM_W;
	localparam int OUT_W     = ptb_pkg::OUT_W;
	localparam int NODE_CAP  = MAX_LEN + 2;
	localparam int GAP_MAX   = 18;
	localparam int IDLE_LIMIT = 60000;

	typedef struct packed {
		logic [OUT_W-1:0] suffix_length;
		logic [OUT_W-1:0] suffix_node;
		logic             created;
		logic [OUT_W-1:0] occurrences;
		logic [OUT_W-1:0] distinct_count;
		logic             full_res;
	} tree_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [SYM_W-1:0]   symbol;
	logic               done;
	logic [OUT_W-1:0]   suffix_length;
	logic [OUT_W-1:0]   suffix_node;
	logic               created;
	logic [OUT_W-1:0]   occurrences;
	logic [OUT_W-1:0]   distinct_count;
	logic               full_res;

	palindromic_tree_builder #(
		.MAX_LEN (MAX_LEN),
		.ALPHABET(ALPHABET)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.symbol        (symbol),
		.done          (done),
		.suffix_length (suffix_length),
		.suffix_node   (suffix_node),
		.created       (created),
		.occurrences   (occurrences),
		.distinct_count(distinct_count),
		.full_res      (full_res)
	);

	// Predicted tree state
	int unsigned text_sym [MAX_LEN+1];
	int          tree_len [NODE_CAP];
	int unsigned tree_link [NODE_CAP];
	int unsigned tree_child [NODE_CAP*ALPHABET];
	int unsigned tree_hits [NODE_CAP];
	int unsigned last_sfx;
	int unsigned text_count;
	int unsigned top_node;

	tree_result_t pending_results[$];
	int           errors;
	int           sent_items;
	int           checked_results;
	int           created_seen;
	int           full_seen;
	int           idle_cycles;
	bit           no_gaps;

	always #5 clk = ~clk;

	function automatic bit can_extend(int unsigned v);
		longint pos;
		pos = longint'(text_count) - longint'(tree_len[v]) - 1;
		if (pos < 1 || pos > longint'(text_count))
			return 0;
		return text_sym[pos] == text_sym[text_count];
	endfunction

	function automatic int unsigned follow_links(int unsigned v);
		int unsigned hops;
		hops = 0;
		while (!can_extend(v) && hops <= NODE_CAP) begin
			v = tree_link[v];
			if (v >= NODE_CAP)
				v = 1;
			hops++;
		end
		return v;
	endfunction

	function automatic tree_result_t append_letter(int unsigned sym);
		tree_result_t r;
		int unsigned cur, node, fresh, up, nxt;
		r = '0;
		r.distinct_count = OUT_W'(top_node - 1);
		if (text_count >= MAX_LEN) begin
			r.full_res = 1'b1;
			return r;
		end
		if (sym >= ALPHABET)
			return r;
		text_count++;
		text_sym[text_count] = sym;
		cur = follow_links(last_sfx);
		node = tree_child[cur*ALPHABET + sym];
		if (node == 0 && top_node + 1 < NODE_CAP) begin
			fresh = top_node + 1;
			nxt = (tree_link[cur] < NODE_CAP) ? tree_link[cur] : 1;
			up = follow_links(nxt);
			top_node = fresh;
			tree_len[fresh] = tree_len[cur] + 2;
			tree_hits[fresh] = 0;
			tree_link[fresh] = tree_child[up*ALPHABET + sym];
			tree_child[cur*ALPHABET + sym] = fresh;
			node = fresh;
			r.created = 1'b1;
		end
		last_sfx = node;
		tree_hits[node]++;
		r.suffix_length  = OUT_W'(tree_len[node]);
		r.suffix_node    = OUT_W'(node);
		r.occurrences    = OUT_W'(tree_hits[node]);
		r.distinct_count = OUT_W'(top_node - 1);
		return r;
	endfunction

	task automatic send_letter(input int unsigned sym);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		symbol <= SYM_W'(sym);
		do @(posedge clk); while (busy);
		pending_results.push_back(append_letter(sym));
		sent_items++;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		int unsigned seq[$];
		// extremes, a palindrome run, out-of-range symbols and repeats
		seq = {0, 25, 0, 25, 0, 26, 31, 16, 1, 1, 1, 2, 1, 1, 0, 0,
			0, 0, 30, 3, 0, 0, 3, 24};
		no_gaps = 1'b0;
		foreach (seq[i])
			send_letter(seq[i]);
	endtask

	task automatic test_pause();
		// hold the sender until the block has answered everything
		start <= 1'b0;
		drain_results();
		repeat ($urandom_range(1, 10)) @(posedge clk);
	endtask

	task automatic test_random_text(input int count);
		int unsigned word[$];
		int unsigned k, len, kind, n;
		n = 0;
		while (n < count) begin
			if ((n / 150) % 3 == 1)
				no_gaps = 1'b1;
			else
				no_gaps = 1'b0;
			kind = $urandom_range(0, 19);
			if (kind < 3) begin
				// noise, including symbols outside the alphabet
				send_letter($urandom_range(0, 31));
				n++;
				continue;
			end
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 26) : $urandom_range(1, 3);
			len = $urandom_range(1, 12);
			word.delete();
			repeat (len) word.push_back($urandom_range(0, k - 1));
			foreach (word[i]) send_letter(word[i]);
			n += len;
			if (kind < 12) begin
				// mirror the word, sometimes around a center letter
				if (kind < 7) begin
					send_letter($urandom_range(0, k - 1));
					n++;
				end
				for (int i = word.size() - 1; i >= 0; i--)
					send_letter(word[i]);
				n += len;
			end else if (kind < 16) begin
				foreach (word[i]) send_letter(word[i]);
				n += len;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [OUT_W-1:0] exp_v,
		input logic [OUT_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		tree_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual node %0d",
					$time, suffix_node);
				errors++;
			end else begin
				e = pending_results.pop_front();
				compare_field("suffix_length", e.suffix_length, suffix_length);
				compare_field("suffix_node", e.suffix_node, suffix_node);
				compare_field("created", e.created, created);
				compare_field("occurrences", e.occurrences, occurrences);
				compare_field("distinct_count", e.distinct_count, distinct_count);
				compare_field("full_res", e.full_res, full_res);
				checked_results++;
				if (e.created) created_seen++;
				if (e.full_res) full_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		symbol = '0;
		errors = 0;
		sent_items = 0;
		checked_results = 0;
		created_seen = 0;
		full_seen = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		foreach (text_sym[i]) text_sym[i] = 0;
		foreach (tree_len[i]) tree_len[i] = 0;
		foreach (tree_link[i]) tree_link[i] = 0;
		foreach (tree_child[i]) tree_child[i] = 0;
		foreach (tree_hits[i]) tree_hits[i] = 0;
		tree_len[1] = -1;
		tree_link[0] = 1;
		tree_link[1] = 0;
		last_sfx = 0;
		text_count = 0;
		top_node = 1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause();
		test_random_text(700);
		test_pause();
		test_random_text(700);

		start <= 1'b0;
		drain_results();
		repeat (30) @(posedge clk);

		$display("Sent %0d letters, checked %0d results: %0d new nodes, %0d full-store replies.",
			sent_items, checked_results, created_seen, full_seen);
		$display("Final text length %0d, distinct palindromes %0d.", text_count, top_node - 1);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
